// ----- rtl/core/oled_spi_page_controller_macros.svh -----
// Assertion macros shared by the checker of the OLED page controller.
`ifndef OLED_SPI_PAGE_CONTROLLER_MACROS_SVH
`define OLED_SPI_PAGE_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define OSPC_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ospc assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define OSPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ospc assertion failed");

`endif

// ----- rtl/core/ospc_pkg.sv -----
// Types, constants and the command decoder of the OLED page controller.
package ospc_pkg;

	localparam int DEF_COLUMNS = 132;
	localparam int DEF_PAGES   = 8;

	// Wide enough for page * COLUMNS + column at the largest geometry.
	localparam int ADDR_W = 12;

	localparam logic [7:0] START_MASK = 8'hC0;
	localparam logic [7:0] START_VAL  = 8'h40;
	localparam logic [7:0] NIB_MASK   = 8'hF0;
	localparam logic [7:0] COL_LO_VAL = 8'h00;
	localparam logic [7:0] COL_HI_VAL = 8'h10;
	localparam logic [7:0] PAGE_VAL   = 8'hB0;
	localparam logic [7:0] DISP_MASK  = 8'hFE;
	localparam logic [7:0] DISP_VAL   = 8'hAE;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_COL_LO,
		OP_COL_HI,
		OP_PAGE,
		OP_DISPLAY
	} cmd_op_t;

	typedef struct packed {
		logic       cmd;
		logic       dc_level;
		logic [7:0] spi_byte;
		logic [2:0] read_page;
		logic [7:0] read_column;
	} req_t;

	typedef struct packed {
		logic       stored;
		logic [7:0] cur_column;
		logic [3:0] cur_page;
		logic       panel_on;
		logic [7:0] read_data;
	} rsp_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} ram_rd_t;

	// Start line wins over the nibble patterns; anything unmatched is a no-op.
	function automatic cmd_op_t decode_cmd(input logic [7:0] b);
		cmd_op_t op;
		op = OP_NONE;
		if ((b & START_MASK) == START_VAL) begin
			op = OP_NONE;
		end else if ((b & NIB_MASK) == COL_LO_VAL) begin
			op = OP_COL_LO;
		end else if ((b & NIB_MASK) == COL_HI_VAL) begin
			op = OP_COL_HI;
		end else if ((b & NIB_MASK) == PAGE_VAL) begin
			op = OP_PAGE;
		end else if ((b & DISP_MASK) == DISP_VAL) begin
			op = OP_DISPLAY;
		end
		return op;
	endfunction

endpackage

// ----- rtl/core/ospc_frame_ram.sv -----
// Frame store: one write port, one read port with registered read data.
module ospc_frame_ram #(
	parameter int DEPTH = ospc_pkg::DEF_COLUMNS * ospc_pkg::DEF_PAGES,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  ospc_pkg::ram_wr_t wr,
	input  ospc_pkg::ram_rd_t rd,
	output logic [7:0]       rd_data
);
	import ospc_pkg::*;

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr[AW-1:0]];
		end
	end

endmodule

// ----- rtl/core/oled_spi_page_controller.sv -----
// Top level of the page-organized OLED controller fed by SPI bytes.
//
//   channel | signals                     | direction | carries
//   --------+-----------------------------+-----------+-----------------------------
//   req     | req_valid, req_stall, req   | in        | SPI byte with D/C, or a read
//   rsp     | rsp_valid, rsp_stall, rsp   | out       | pointers, store flag, read byte
//
// One request per cycle while nothing stalls; the input register loads at the
// accepting edge and the result register, beside the frame store's registered
// read, loads from it once the result register is free.
// After reset a clearing pass zeroes the store one byte a cycle, all COLUMNS * PAGES
// bytes (1056 by default), with req_stall held high. rsp_stall holds the result register;
// outside that pass req_stall rises only when a held input request cannot move on.
module oled_spi_page_controller #(
	parameter int COLUMNS = ospc_pkg::DEF_COLUMNS,
	parameter int PAGES   = ospc_pkg::DEF_PAGES
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ospc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ospc_pkg::rsp_t rsp
);
	import ospc_pkg::*;

	localparam int DEPTH = COLUMNS * PAGES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Input stage
	logic valid_s1;
	req_t req_s1;

	// Result stage
	logic       valid_s2;
	logic       stored_s2;
	logic [7:0] col_s2;
	logic [3:0] page_s2;
	logic       disp_s2;
	logic       hit_s2;

	// Architectural state
	logic [7:0] col_q;
	logic [3:0] page_q;
	logic       disp_q;

	// Clearing pass
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	logic       advance_s1;
	logic       accept;
	logic [7:0] col_d;
	logic [3:0] page_d;
	logic       disp_d;
	logic       stored_d;
	logic       hit_d;
	logic       data_ok;
	logic       rd_ok;
	logic [ADDR_W-1:0] wr_addr_calc;
	logic [ADDR_W-1:0] rd_addr_calc;
	ram_wr_t    wr;
	ram_rd_t    rd;
	logic [7:0] rd_data;

	// The result register frees up when it is empty or being taken.
	assign advance_s1 = !valid_s2 || !rsp_stall;
	assign req_stall  = clearing_q || (valid_s1 && !advance_s1);
	assign accept     = req_valid && !req_stall;

	// Range checks: pages go up to 16, so compare on five bits.
	assign data_ok = (col_q < 8'(COLUMNS)) && ({1'b0, page_q} < 5'(PAGES));
	assign rd_ok   = (req_s1.read_column < 8'(COLUMNS))
	               && ({2'b00, req_s1.read_page} < 5'(PAGES));

	// Row-major address: page * COLUMNS + column.
	assign wr_addr_calc = ADDR_W'(page_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
	assign rd_addr_calc = ADDR_W'(req_s1.read_page) * ADDR_W'(COLUMNS)
	                    + ADDR_W'(req_s1.read_column);

	// Work out the step for the request in the input register.
	always_comb begin
		col_d    = col_q;
		page_d   = page_q;
		disp_d   = disp_q;
		stored_d = 1'b0;
		hit_d    = req_s1.cmd && rd_ok;
		wr       = '0;
		rd       = '0;
		rd.addr  = rd_addr_calc;
		wr.addr  = wr_addr_calc;
		wr.data  = req_s1.spi_byte;
		if (clearing_q) begin
			// Sweep zeros through the store; no request is in flight.
			wr.en   = 1'b1;
			wr.addr = ADDR_W'(clr_addr_q);
			wr.data = '0;
		end else if (valid_s1 && advance_s1) begin
			if (req_s1.cmd) begin
				rd.en = rd_ok;
			end else if (req_s1.dc_level) begin
				// Store one column byte and advance; drop it when out of range.
				if (data_ok) begin
					wr.en    = 1'b1;
					col_d    = col_q + 8'd1;
					stored_d = 1'b1;
				end
			end else begin
				case (decode_cmd(req_s1.spi_byte))
					OP_COL_LO:  col_d  = {col_q[7:4], req_s1.spi_byte[3:0]};
					OP_COL_HI:  col_d  = {req_s1.spi_byte[3:0], col_q[3:0]};
					OP_PAGE:    page_d = req_s1.spi_byte[3:0];
					OP_DISPLAY: disp_d = req_s1.spi_byte[0];
					default:    ;
				endcase
			end
		end
	end

	ospc_frame_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	// Control state: stage valids, pointers, clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			col_q      <= '0;
			page_q     <= '0;
			disp_q     <= 1'b0;
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance_s1) begin
				valid_s1 <= 1'b0;
			end
			if (advance_s1) begin
				valid_s2 <= valid_s1;
			end
			col_q  <= col_d;
			page_q <= page_d;
			disp_q <= disp_d;
			if (clearing_q) begin
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
		end
	end

	// Payload registers: hold while stalled, load on advance.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (valid_s1 && advance_s1) begin
			stored_s2 <= stored_d;
			col_s2    <= col_d;
			page_s2   <= page_d;
			disp_s2   <= disp_d;
			hit_s2    <= hit_d;
		end
	end

	assign rsp_valid      = valid_s2;
	assign rsp.stored     = stored_s2;
	assign rsp.cur_column = col_s2;
	assign rsp.cur_page   = page_s2;
	assign rsp.panel_on   = disp_s2;
	// Out-of-range reads and SPI steps report zero.
	assign rsp.read_data  = hit_s2 ? rd_data : 8'd0;

endmodule

// ----- rtl/core/ospc_checker.sv -----
// Port checker for the OLED page controller, bound to the top level.
`include "oled_spi_page_controller_macros.svh"

module ospc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input ospc_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input ospc_pkg::rsp_t rsp
);
	import ospc_pkg::*;

	// A stored byte advanced the column, so it cannot read zero, and a
	// store step never returns frame data.
	`OSPC_ASSERT_IMPLY(a_store_result, rsp_valid && rsp.stored, (rsp.cur_column != 8'd0) && (rsp.read_data == 8'd0))

	// The clearing pass blocks requests right after reset.
	`OSPC_ASSERT_IMPLY(a_clear_after_reset, !$past(arst_n), req_stall && !rsp_valid)

	// A stalled result holds.
	`OSPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// A stalled request holds.
	`OSPC_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req))

endmodule

bind oled_spi_page_controller ospc_checker u_ospc_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for the SPI-fed OLED page controller.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ospc_pkg::*;

	localparam int COLUMNS     = DEF_COLUMNS;
	localparam int PAGES       = DEF_PAGES;
	localparam int CYCLE_LIMIT = 200000;
	localparam int CHUNK_ITEMS = 80;
	localparam int DRAIN_WAIT  = 10;

	// Traffic phases: which side idles or stalls, and how often.
	typedef enum logic [1:0] {
		PH_FREE,
		PH_SEND_GAPS,
		PH_RSP_STALLS,
		PH_BOTH
	} phase_e;

	typedef struct packed {
		req_t   req;
		phase_e phase;
		logic   wait_drain;
	} backlog_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	oled_spi_page_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Requests not yet offered, and the status each accepted request must produce.
	backlog_t spi_backlog [$];
	rsp_t     status_due [$];

	// Shadow copy of the controller: pointers, panel flag and the frame store.
	logic [7:0] col_pos       = '0;
	logic [3:0] page_pos      = '0;
	logic       panel_enabled = 1'b0;
	logic [7:0] shadow_frame [COLUMNS*PAGES];

	int     mismatches   = 0;
	int     cycles       = 0;
	int     accepted     = 0;
	int     total_items  = 0;
	logic   req_taken    = 1'b0;
	phase_e phase_now    = PH_FREE;
	phase_e fill_phase   = PH_FREE;
	logic   fill_drain   = 1'b0;
	int     idle_pct;
	int     stall_pct;

	// Apply one request to the shadow state and return the status it yields.
	function automatic rsp_t next_panel_status(input req_t r);
		rsp_t    s;
		cmd_op_t op;
		logic [7:0] b;
		s = '0;
		b = r.spi_byte;
		if (r.cmd) begin
			// read: out-of-range positions give zero, nothing else moves
			if (int'(r.read_column) < COLUMNS && int'(r.read_page) < PAGES)
				s.read_data = shadow_frame[int'(r.read_page) * COLUMNS + int'(r.read_column)];
		end else if (r.dc_level) begin
			// data byte: store and advance, or drop when the pointers are off the panel
			if (int'(col_pos) < COLUMNS && int'(page_pos) < PAGES) begin
				shadow_frame[int'(page_pos) * COLUMNS + int'(col_pos)] = b;
				col_pos  = col_pos + 8'd1;
				s.stored = 1'b1;
			end
		end else begin
			// start line masks out the wider range first
			op = OP_NONE;
			if ((b & START_MASK) != START_VAL) begin
				case (b & NIB_MASK)
					COL_LO_VAL: op = OP_COL_LO;
					COL_HI_VAL: op = OP_COL_HI;
					PAGE_VAL:   op = OP_PAGE;
					default:    op = ((b & DISP_MASK) == DISP_VAL) ? OP_DISPLAY : OP_NONE;
				endcase
			end
			case (op)
				OP_COL_LO:  col_pos[3:0]  = b[3:0];
				OP_COL_HI:  col_pos[7:4]  = b[3:0];
				OP_PAGE:    page_pos      = b[3:0];
				OP_DISPLAY: panel_enabled = b[0];
				default: ;
			endcase
		end
		s.cur_column = col_pos;
		s.cur_page   = page_pos;
		s.panel_on   = panel_enabled;
		return s;
	endfunction

	function automatic req_t spi_req(input logic dc, input logic [7:0] b);
		req_t r;
		r             = '0;
		r.cmd         = 1'b0;
		r.dc_level    = dc;
		r.spi_byte    = b;
		// read fields are don't-care here; toggle them anyway
		r.read_page   = 3'($urandom);
		r.read_column = 8'($urandom);
		return r;
	endfunction

	function automatic req_t read_req(input logic [2:0] pg, input logic [7:0] col);
		req_t r;
		r             = '0;
		r.cmd         = 1'b1;
		r.dc_level    = 1'($urandom);
		r.spi_byte    = 8'($urandom);
		r.read_page   = pg;
		r.read_column = col;
		return r;
	endfunction

	task automatic push_req(input req_t r);
		backlog_t item;
		item.req        = r;
		item.phase      = fill_phase;
		item.wait_drain = fill_drain;
		fill_drain      = 1'b0;
		spi_backlog.push_back(item);
		total_items++;
	endtask

	// Queue one random sequence: mostly address-then-burst writes, then noise.
	task automatic queue_random_sequence(inout int count);
		int       pick;
		int       burst;
		logic [7:0] target;
		logic [3:0] pg;
		pick = $urandom_range(99);
		if (pick < 70) begin
			pg     = ($urandom_range(9) != 0) ? 4'($urandom_range(PAGES-1))
				: 4'($urandom_range(15, PAGES));
			target = ($urandom_range(6) != 0) ? 8'($urandom_range(COLUMNS-1))
				: 8'($urandom_range(255, COLUMNS));
			push_req(spi_req(1'b0, PAGE_VAL | {4'h0, pg}));
			if ($urandom_range(1)) begin
				push_req(spi_req(1'b0, COL_LO_VAL | {4'h0, target[3:0]}));
				push_req(spi_req(1'b0, COL_HI_VAL | {4'h0, target[7:4]}));
			end else begin
				push_req(spi_req(1'b0, COL_HI_VAL | {4'h0, target[7:4]}));
				push_req(spi_req(1'b0, COL_LO_VAL | {4'h0, target[3:0]}));
			end
			burst = $urandom_range(8, 1);
			for (int i = 0; i < burst; i++)
				push_req(spi_req(1'b1, 8'($urandom)));
			count += 3 + burst;
			// read back somewhere inside the burst just written
			if ($urandom_range(1)) begin
				push_req(read_req(pg[2:0], target + 8'($urandom_range(burst-1))));
				count++;
			end
		end else if (pick < 80) begin
			push_req(spi_req(1'b0, DISP_VAL | 8'($urandom_range(1))));
			count++;
		end else if (pick < 88) begin
			push_req(read_req(3'($urandom), 8'($urandom)));
			count++;
		end else begin
			push_req(req_t'($urandom));
			count++;
		end
	endtask

	// Driver: offer the next request on the falling edge, hold it while stalled.
	always @(negedge clk) begin
		backlog_t head;
		if (spi_backlog.size() != 0)
			phase_now = spi_backlog[0].phase;
		case (phase_now)
			PH_SEND_GAPS:  begin idle_pct = 49; stall_pct = 0;  end
			PH_RSP_STALLS: begin idle_pct = 0;  stall_pct = 49; end
			PH_BOTH:       begin idle_pct = 11; stall_pct = 11; end
			default:       begin idle_pct = 0;  stall_pct = 0;  end
		endcase
		rsp_stall <= ($urandom_range(99) < stall_pct);
		if (!req_valid || req_taken) begin
			// hold off a marked request until every outstanding status is back
			if (spi_backlog.size() != 0
				&& !(spi_backlog[0].wait_drain && status_due.size() != 0)
				&& $urandom_range(99) >= idle_pct) begin
				head       = spi_backlog.pop_front();
				req       <= head.req;
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Monitor: predict on every accepted request, compare every accepted status.
	always @(posedge clk) begin
		rsp_t want;
		cycles++;
		req_taken <= arst_n && req_valid && !req_stall;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (status_due.size() == 0) begin
					$error("status returned with no request outstanding");
					mismatches++;
				end else begin
					want = status_due.pop_front();
					check_field("stored",     want.stored,     rsp.stored);
					check_field("cur_column", want.cur_column, rsp.cur_column);
					check_field("cur_page",   want.cur_page,   rsp.cur_page);
					check_field("panel_on",   want.panel_on,   rsp.panel_on);
					check_field("read_data",  want.read_data,  rsp.read_data);
				end
			end
			if (req_valid && !req_stall) begin
				status_due.push_back(next_panel_status(req));
				accepted++;
			end
		end
		// give up if the run stalls
		if (cycles >= CYCLE_LIMIT) begin
			$display("oled_spi_page_controller test failed");
			$finish;
		end
	end

	initial begin
		int count;
		foreach (shadow_frame[i])
			shadow_frame[i] = '0;

		// Directed: cleared store, pointer edges, drops, every command kind.
		fill_phase = PH_FREE;
		push_req(read_req(3'd0, 8'd0));
		push_req(read_req(3'd7, 8'(COLUMNS-1)));
		push_req(read_req(3'd3, 8'(COLUMNS)));
		push_req(read_req(3'd5, 8'hFF));
		push_req(spi_req(1'b0, DISP_VAL | 8'h01));
		push_req(spi_req(1'b0, DISP_VAL));
		push_req(spi_req(1'b0, DISP_VAL | 8'h01));
		push_req(spi_req(1'b1, 8'hFF));
		push_req(spi_req(1'b1, 8'hA5));
		// park at the last column of the last page, write it, then overrun
		push_req(spi_req(1'b0, COL_LO_VAL | 8'h03));
		push_req(spi_req(1'b0, COL_HI_VAL | 8'h08));
		push_req(spi_req(1'b0, PAGE_VAL | 8'h07));
		push_req(spi_req(1'b1, 8'h5A));
		push_req(spi_req(1'b1, 8'hC3));
		push_req(read_req(3'd7, 8'(COLUMNS-1)));
		// column pointer pushed to its top via both nibbles
		push_req(spi_req(1'b0, COL_HI_VAL | 8'h0F));
		push_req(spi_req(1'b0, COL_LO_VAL | 8'h0F));
		push_req(spi_req(1'b1, 8'h81));
		// page beyond the panel drops data even at column zero
		push_req(spi_req(1'b0, PAGE_VAL | 8'h0F));
		push_req(spi_req(1'b0, COL_LO_VAL));
		push_req(spi_req(1'b0, COL_HI_VAL));
		push_req(spi_req(1'b1, 8'h3C));
		// start line and unmatched bytes leave everything alone
		push_req(spi_req(1'b0, START_VAL));
		push_req(spi_req(1'b0, START_VAL | 8'h3F));
		push_req(spi_req(1'b0, 8'hFF));
		push_req(spi_req(1'b0, PAGE_VAL));
		push_req(spi_req(1'b1, 8'h66));
		push_req(read_req(3'd0, 8'd0));
		push_req(read_req(3'd0, 8'd1));

		// Five random chunks cycling through the traffic phases (PH_FREE twice), each opened after a full drain.
		for (int p = 0; p < 5; p++) begin
			fill_phase = phase_e'(p % 4);
			fill_drain = 1'b1;
			count      = 0;
			while (count < CHUNK_ITEMS)
				queue_random_sequence(count);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (accepted != total_items || status_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		if (mismatches == 0) begin
			$display("oled_spi_page_controller test passed");
		end else begin
			$display("oled_spi_page_controller test failed");
		end
		$finish;
	end

endmodule
